// File: hdl/pcr_pkg.sv
// Package for the particle contact resolver: field widths, fixed-point
// constants and width helpers shared by pcr_in_if and all modules.
// No dependencies.
package pcr_pkg;

  localparam int NormBits   = 16;  // one normal component, Q1.14
  localparam int NormFrac   = 14;
  localparam int ImBits     = 24;  // inverse mass, Q8.16
  localparam int TotalBits  = 25;  // sum of two inverse masses
  localparam int RestBits   = 17;  // restitution, Q1.16
  localparam int PenBits    = 19;  // penetration depth
  localparam int RatioBits  = 17;  // mass ratio, Q0.16 up to one
  localparam int RatioFrac  = 16;
  localparam int DivRemBits = 42;  // divider remainder, holds den << 16
  localparam int Q16One     = 65536;
  localparam int QDepth     = 4;   // entries between front and back

  // Width of the signed separating speed, exact in Q(F+14)
  function automatic int vs_width(input int cb);
    return cb + 19;
  endfunction

  // Width of one queue word
  function automatic int item_width(input int cb);
    return 12 * cb + 3 * NormBits + ImBits + TotalBits + RestBits + PenBits
           + vs_width(cb);
  endfunction

endpackage

// File: hdl/pcr_if.sv
// Valid/ready channel interfaces for contact words and result words.
// Depends on pcr_pkg.
interface pcr_in_if import pcr_pkg::*; #(parameter int CB = 20);
  logic                  valid;
  logic                  ready;
  logic [3*CB-1:0]       a_position;
  logic [3*CB-1:0]       a_velocity;
  logic [3*CB-1:0]       b_position;
  logic [3*CB-1:0]       b_velocity;
  logic [3*NormBits-1:0] contact_normal;
  logic [ImBits-1:0]     a_inverse_mass;
  logic [ImBits-1:0]     b_inverse_mass;
  logic [RestBits-1:0]   restitution;
  logic [PenBits-1:0]    penetration;
  logic                  has_second;

  modport source (output valid, a_position, a_velocity, b_position, b_velocity,
                  contact_normal, a_inverse_mass, b_inverse_mass, restitution,
                  penetration, has_second, input ready);
  modport sink (input valid, a_position, a_velocity, b_position, b_velocity,
                contact_normal, a_inverse_mass, b_inverse_mass, restitution,
                penetration, has_second, output ready);
endinterface

interface pcr_out_if #(parameter int CB = 20);
  logic            valid;
  logic            ready;
  logic [3*CB-1:0] new_a_position;
  logic [3*CB-1:0] new_a_velocity;
  logic [3*CB-1:0] new_b_position;
  logic [3*CB-1:0] new_b_velocity;
  logic            impulse_applied;

  modport source (output valid, new_a_position, new_a_velocity, new_b_position,
                  new_b_velocity, impulse_applied, input ready);
  modport sink (input valid, new_a_position, new_a_velocity, new_b_position,
                new_b_velocity, impulse_applied, output ready);
endinterface

// File: hdl/pcr_front.sv
// Front end: takes contact words, forms the separating speed along the normal,
// the total inverse mass and the clamped restitution, and pushes a queue word.
// Depends on pcr_pkg and pcr_in_if.
module pcr_front import pcr_pkg::*; #(
  parameter int CB = 20,
  localparam int VW = vs_width(CB),
  localparam int IW = item_width(CB)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pcr_in_if.sink        ctc_i,
  output logic          push_o,
  output logic [IW-1:0] item_o,
  input  logic          full_i
);

  localparam int DW = CB + 1;            // velocity difference
  localparam int PW = DW + NormBits;     // difference times normal

  logic                   s1_valid_q;
  logic                   s1_adv;
  logic [3*CB-1:0]        pa_q, va_q, pb_q, vb_q;
  logic [3*NormBits-1:0]  n_q;
  logic [ImBits-1:0]      ima_q, imb_q;
  logic [RestBits-1:0]    e_q, e_d;
  logic [PenBits-1:0]     pen_q;
  logic signed [PW-1:0]   prod_d [3];
  logic signed [PW-1:0]   prod_q [3];
  logic signed [VW-1:0]   vs_c;
  logic [TotalBits-1:0]   total_c;

  // stage moves when empty or when the queue takes its word
  assign s1_adv      = !s1_valid_q || !full_i;
  assign ctc_i.ready = s1_adv;
  assign push_o      = s1_valid_q && !full_i;

  // per-axis (vA - vB) * n, vB zero against ground
  always_comb begin
    logic signed [DW-1:0]       va_c, vb_c, diff;
    logic signed [NormBits-1:0] n_c;
    for (int i = 0; i < 3; i++) begin
      va_c = DW'(signed'(ctc_i.a_velocity[i*CB +: CB]));
      vb_c = ctc_i.has_second ? DW'(signed'(ctc_i.b_velocity[i*CB +: CB])) : '0;
      diff = va_c - vb_c;
      n_c  = signed'(ctc_i.contact_normal[i*NormBits +: NormBits]);
      prod_d[i] = PW'(diff) * PW'(n_c);
    end
  end

  // restitution above one is clamped
  always_comb begin
    if (ctc_i.restitution > RestBits'(Q16One)) begin
      e_d = RestBits'(Q16One);
    end else begin
      e_d = ctc_i.restitution;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= ctc_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && ctc_i.valid) begin
      pa_q   <= ctc_i.a_position;
      va_q   <= ctc_i.a_velocity;
      pb_q   <= ctc_i.b_position;
      vb_q   <= ctc_i.b_velocity;
      n_q    <= ctc_i.contact_normal;
      ima_q  <= ctc_i.a_inverse_mass;
      imb_q  <= ctc_i.has_second ? ctc_i.b_inverse_mass : '0;
      e_q    <= e_d;
      pen_q  <= ctc_i.penetration;
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= prod_d[i];
      end
    end
  end

  // separating speed and total inverse mass
  assign vs_c    = VW'(prod_q[0]) + VW'(prod_q[1]) + VW'(prod_q[2]);
  assign total_c = {1'b0, ima_q} + {1'b0, imb_q};

  assign item_o = {pa_q, va_q, pb_q, vb_q, n_q, ima_q, total_c, e_q, pen_q, vs_c};

endmodule

// File: hdl/pcr_fifo.sv
// Short register queue between front and back end.
// Depends on pcr_pkg.
module pcr_fifo import pcr_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int AW = $clog2(QDepth);
  localparam int CW = $clog2(QDepth + 1);

  logic [W-1:0]  mem_q [QDepth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign full_o  = (count_q == CW'(QDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // occupancy and pointers must agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QDepth))
    else $error("queue count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == CW'(QDepth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers out of step with count");

endmodule

// File: hdl/pcr_div.sv
// Pipelined restoring divider: (ima << 16) / total, one quotient bit a stage,
// with a payload carried alongside. Depends on pcr_pkg.
module pcr_div import pcr_pkg::*; #(
  parameter int PW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic [ImBits-1:0]    num_i,
  input  logic [TotalBits-1:0] den_i,
  input  logic [PW-1:0]        pay_i,
  output logic                 valid_o,
  output logic [RatioBits-1:0] quo_o,
  output logic                 rem_zero_o,
  output logic [PW-1:0]        pay_o
);

  localparam int NS = RatioBits;

  logic [NS-1:0]          v_q;
  logic [DivRemBits-1:0]  rem_q [NS];
  logic [RatioBits-1:0]   quo_q [NS];
  logic [TotalBits-1:0]   den_q [NS];
  logic [PW-1:0]          pay_q [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    localparam int K = NS - 1 - j;
    logic                  v_in;
    logic [DivRemBits-1:0] rem_in, sub;
    logic [RatioBits-1:0]  q_in;
    logic [TotalBits-1:0]  d_in;
    logic [PW-1:0]         p_in;
    logic                  ge;

    if (j == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = DivRemBits'({num_i, {RatioFrac{1'b0}}});
      assign q_in   = '0;
      assign d_in   = den_i;
      assign p_in   = pay_i;
    end else begin : g_next
      assign v_in   = v_q[j-1];
      assign rem_in = rem_q[j-1];
      assign q_in   = quo_q[j-1];
      assign d_in   = den_q[j-1];
      assign p_in   = pay_q[j-1];
    end

    // trial subtract of den << K
    assign sub = DivRemBits'(d_in) << K;
    assign ge  = (rem_in >= sub);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (adv_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[j] <= ge ? (rem_in - sub) : rem_in;
        quo_q[j] <= ge ? (q_in | (RatioBits'(1) << K)) : q_in;
        den_q[j] <= d_in;
        pay_q[j] <= p_in;
      end
    end
  end

  assign valid_o    = v_q[NS-1];
  assign quo_o      = quo_q[NS-1];
  assign rem_zero_o = (rem_q[NS-1] == '0);
  assign pay_o      = pay_q[NS-1];

  // a finished remainder is below a nonzero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NS-1] && den_q[NS-1] != '0) |-> (rem_q[NS-1] < DivRemBits'(den_q[NS-1])))
    else $error("divider remainder not below divisor");

endmodule

// File: hdl/pcr_back.sv
// Back end: mass ratios through the divider, then impulse and separation
// multiplies, saturating adds and the output register. Depends on pcr_pkg,
// pcr_div and pcr_out_if.
module pcr_back import pcr_pkg::*; #(
  parameter int CB = 20,
  localparam int VW = vs_width(CB),
  localparam int IW = item_width(CB)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [IW-1:0] item_i,
  input  logic          empty_i,
  output logic          pop_o,
  pcr_out_if.source     res_o
);

  // queue word layout
  localparam int O_PEN = VW;
  localparam int O_E   = O_PEN + PenBits;
  localparam int O_TOT = O_E + RestBits;
  localparam int O_IMA = O_TOT + TotalBits;
  localparam int O_N   = O_IMA + ImBits;
  // divider payload layout: vectors, normal, e, pen, vs, zero-mass flag
  localparam int PW    = IW - ImBits - TotalBits + 1;
  localparam int Q_VS  = 1;
  localparam int Q_PEN = Q_VS + VW;
  localparam int Q_E   = Q_PEN + PenBits;
  localparam int Q_N   = Q_E + RestBits;
  localparam int VBW   = 12 * CB + 3 * NormBits;   // vectors and normal

  localparam int SFW = VW + RestBits + 1;          // |vs| * (1 + e)
  localparam int SW  = SFW - RatioFrac;            // s
  localparam int TW  = SW + RatioBits;             // s * r
  localparam int PRW = PenBits + RatioBits;        // pen * r
  localparam int PPW = PRW - RatioFrac + 1 + NormBits;
  localparam int VPW = TW - RatioFrac + 1 + NormBits;
  localparam int WW  = VPW + 2;                    // sum width

  logic adv;
  logic out_valid_q;

  // whole back end steps when the output register frees
  assign adv   = !out_valid_q || res_o.ready;
  assign pop_o = adv && !empty_i;

  // divider: ratio of A
  logic                 dv_valid, dv_rem_zero;
  logic [RatioBits-1:0] dv_quo;
  logic [PW-1:0]        dv_pay, pay_in;
  logic                 tz_in;

  assign tz_in  = (item_i[O_IMA-1:O_TOT] == '0);
  assign pay_in = {item_i[IW-1:O_N], item_i[O_TOT-1:0], tz_in};

  pcr_div #(.PW(PW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (!empty_i),
    .num_i      (item_i[O_N-1:O_IMA]),
    .den_i      (item_i[O_IMA-1:O_TOT]),
    .pay_i      (pay_in),
    .valid_o    (dv_valid),
    .quo_o      (dv_quo),
    .rem_zero_o (dv_rem_zero),
    .pay_o      (dv_pay)
  );

  function automatic logic signed [WW-1:0] stz(input logic signed [WW-1:0] x,
                                               input int k);
    logic [WW-1:0] m;
    m = x[WW-1] ? unsigned'(-x) : unsigned'(x);
    m = m >> k;
    return x[WW-1] ? -signed'(m) : signed'(m);
  endfunction

  function automatic logic [CB-1:0] sat_c(input logic signed [WW-1:0] x);
    logic signed [WW-1:0] hi, lo;
    hi = signed'({{(WW-CB+1){1'b0}}, {(CB-1){1'b1}}});
    lo = ~hi;
    if (x > hi) begin
      return hi[CB-1:0];
    end else if (x < lo) begin
      return lo[CB-1:0];
    end
    return x[CB-1:0];
  endfunction

  // M1: ratios, impulse scale and penetration scale
  logic                 m1_v_q, m1_app_q;
  logic [VBW-1:0]       m1_vec_q;
  logic [RatioBits-1:0] m1_ra_q, m1_rb_q, ra_d, rb_d;
  logic [SFW-1:0]       m1_sf_q, sf_d;
  logic [PRW-1:0]       m1_pra_q, m1_prb_q;
  logic                 closing_d, tz_w;
  logic signed [VW-1:0] vs_w;
  logic [VW-1:0]        mag;
  logic [RestBits:0]    kmul;
  logic [RatioBits:0]   rb_w;
  logic [PenBits-1:0]   pen_w;

  always_comb begin
    tz_w      = dv_pay[0];
    vs_w      = signed'(dv_pay[Q_PEN-1:Q_VS]);
    pen_w     = dv_pay[Q_E-1:Q_PEN];
    closing_d = !tz_w && vs_w[VW-1];
    mag       = closing_d ? unsigned'(-vs_w) : '0;
    kmul      = {1'b0, dv_pay[Q_N-1:Q_E]} + (RestBits+1)'(Q16One);
    sf_d      = SFW'(mag) * SFW'(kmul);
    // B ratio from A's quotient and remainder
    rb_w      = (RatioBits+1)'(Q16One) - {1'b0, dv_quo} - (RatioBits+1)'(!dv_rem_zero);
    ra_d      = tz_w ? '0 : dv_quo;
    rb_d      = tz_w ? '0 : rb_w[RatioBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else if (adv) begin
      m1_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_app_q <= closing_d;
      m1_vec_q <= dv_pay[PW-1:Q_N];
      m1_ra_q  <= ra_d;
      m1_rb_q  <= rb_d;
      m1_sf_q  <= sf_d;
      m1_pra_q <= PRW'(pen_w) * PRW'(ra_d);
      m1_prb_q <= PRW'(pen_w) * PRW'(rb_d);
    end
  end

  // M2: per-body impulse magnitude, position moves times normal
  logic                  m2_v_q, m2_app_q;
  logic [VBW-1:0]        m2_vec_q;
  logic [TW-1:0]         m2_ta_q, m2_tb_q;
  logic signed [PPW-1:0] m2_ppa_q [3];
  logic signed [PPW-1:0] m2_ppb_q [3];
  logic signed [PPW-1:0] ppa_d [3];
  logic signed [PPW-1:0] ppb_d [3];
  logic [SW-1:0]         s_w;

  assign s_w = m1_sf_q[SFW-1:RatioFrac];

  always_comb begin
    logic signed [PRW-RatioFrac:0] mova, movb;
    logic signed [NormBits-1:0]    n_c;
    mova = signed'({1'b0, m1_pra_q[PRW-1:RatioFrac]});
    movb = signed'({1'b0, m1_prb_q[PRW-1:RatioFrac]});
    for (int i = 0; i < 3; i++) begin
      n_c      = signed'(m1_vec_q[i*NormBits +: NormBits]);
      ppa_d[i] = PPW'(mova) * PPW'(n_c);
      ppb_d[i] = PPW'(movb) * PPW'(n_c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_v_q <= 1'b0;
    end else if (adv) begin
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_app_q <= m1_app_q;
      m2_vec_q <= m1_vec_q;
      m2_ta_q  <= TW'(s_w) * TW'(m1_ra_q);
      m2_tb_q  <= TW'(s_w) * TW'(m1_rb_q);
      for (int i = 0; i < 3; i++) begin
        m2_ppa_q[i] <= ppa_d[i];
        m2_ppb_q[i] <= ppb_d[i];
      end
    end
  end

  // M3: velocity deltas times normal; new positions
  logic                  m3_v_q, m3_app_q;
  logic [VBW-1:0]        m3_vec_q;
  logic [3*CB-1:0]       m3_pa_q, m3_pb_q, npa_d, npb_d;
  logic signed [VPW-1:0] m3_tva_q [3];
  logic signed [VPW-1:0] m3_tvb_q [3];
  logic signed [VPW-1:0] tva_d [3];
  logic signed [VPW-1:0] tvb_d [3];

  localparam int O_VVB = 3 * NormBits;
  localparam int O_VPB = O_VVB + 3 * CB;
  localparam int O_VVA = O_VPB + 3 * CB;
  localparam int O_VPA = O_VVA + 3 * CB;

  always_comb begin
    logic signed [TW-RatioFrac:0] ta_s, tb_s;
    logic signed [NormBits-1:0]   n_c;
    ta_s = signed'({1'b0, m2_ta_q[TW-1:RatioFrac]});
    tb_s = signed'({1'b0, m2_tb_q[TW-1:RatioFrac]});
    for (int i = 0; i < 3; i++) begin
      n_c      = signed'(m2_vec_q[i*NormBits +: NormBits]);
      tva_d[i] = VPW'(ta_s) * VPW'(n_c);
      tvb_d[i] = VPW'(tb_s) * VPW'(n_c);
      npa_d[i*CB +: CB] = sat_c(WW'(signed'(m2_vec_q[O_VPA + i*CB +: CB]))
                                + stz(WW'(m2_ppa_q[i]), NormFrac));
      npb_d[i*CB +: CB] = sat_c(WW'(signed'(m2_vec_q[O_VPB + i*CB +: CB]))
                                - stz(WW'(m2_ppb_q[i]), NormFrac));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_v_q <= 1'b0;
    end else if (adv) begin
      m3_v_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m3_app_q <= m2_app_q;
      m3_vec_q <= m2_vec_q;
      m3_pa_q  <= npa_d;
      m3_pb_q  <= npb_d;
      for (int i = 0; i < 3; i++) begin
        m3_tva_q[i] <= tva_d[i];
        m3_tvb_q[i] <= tvb_d[i];
      end
    end
  end

  // M4: new velocities into the output register
  logic [3*CB-1:0] nva_d, nvb_d;
  logic [3*CB-1:0] o_pa_q, o_va_q, o_pb_q, o_vb_q;
  logic            o_app_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nva_d[i*CB +: CB] = sat_c(WW'(signed'(m3_vec_q[O_VVA + i*CB +: CB]))
                                + stz(WW'(m3_tva_q[i]), 2 * NormFrac));
      nvb_d[i*CB +: CB] = sat_c(WW'(signed'(m3_vec_q[O_VVB + i*CB +: CB]))
                                - stz(WW'(m3_tvb_q[i]), 2 * NormFrac));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= m3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_pa_q  <= m3_pa_q;
      o_va_q  <= nva_d;
      o_pb_q  <= m3_pb_q;
      o_vb_q  <= nvb_d;
      o_app_q <= m3_app_q;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.new_a_position  = o_pa_q;
  assign res_o.new_a_velocity  = o_va_q;
  assign res_o.new_b_position  = o_pb_q;
  assign res_o.new_b_velocity  = o_vb_q;
  assign res_o.impulse_applied = o_app_q;

  // the two ratios cover the whole unit, less at most one lsb of rounding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m1_v_q && m1_ra_q != '0) |->
      ((18'(m1_ra_q) + 18'(m1_rb_q) == 18'(Q16One)) ||
       (18'(m1_ra_q) + 18'(m1_rb_q) == 18'(Q16One - 1))))
    else $error("mass ratios do not sum to one");
  // no impulse without an inverse mass on A or B
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m1_v_q && m1_app_q) |-> (m1_ra_q != '0 || m1_rb_q != '0))
    else $error("impulse flagged with zero total inverse mass");

endmodule

// File: hdl/particle_contact_resolver_unit.sv
// Particle contact resolver, top level: front end, queue, back end.
// Contact path: front stage, queue, 17-stage ratio divider, M1-M3, output reg.
// Fully pipelined; one contact per cycle unless the output stalls.
// Reset (asynchronous, active low) empties the front stage, queue and pipeline.
// Depends on pcr_pkg, pcr_if, pcr_front, pcr_fifo, pcr_div and pcr_back.
module particle_contact_resolver_unit import pcr_pkg::*; #(
  parameter int COMPONENT_BITS = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcr_in_if.sink     ctc_i,
  pcr_out_if.source  res_o
);

  localparam int IW = item_width(COMPONENT_BITS);

  logic          push, full, pop, empty;
  logic [IW-1:0] wr_item, rd_item;

  pcr_front #(.CB(COMPONENT_BITS)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctc_i  (ctc_i),
    .push_o (push),
    .item_o (wr_item),
    .full_i (full)
  );

  pcr_fifo #(.W(IW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (wr_item),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (rd_item),
    .empty_o (empty)
  );

  pcr_back #(.CB(COMPONENT_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (rd_item),
    .empty_i (empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule
